@@ src/mjdc_pkg.sv @@
// shared types, constants and tables for the mjd to calendar date converter
package mjdc_pkg;

  localparam int MJD_W = 23;
  localparam int MS_W = 27;
  localparam int Z_W = 24;

  localparam logic [MS_W-1:0] MS_PER_DAY = 27'd86400000;
  localparam logic signed [Z_W-1:0] JD_OFFSET = 24'sd2400001;
  localparam logic signed [Z_W-1:0] GREG_START = 24'sd2299161;

  // alpha = floor((4z - 7468865) / 146097) by exact reciprocal
  localparam int AN_W = 25;
  localparam logic [26:0] ALPHA_BIAS = 27'd7468865;
  localparam logic [25:0] ALPHA_MUL = 26'd60207212;
  localparam int ALPHA_SHIFT = 43;
  localparam int ALPHA_PW = 51;

  localparam logic signed [Z_W-1:0] B_OFFSET = 24'sd1524;

  // c = floor((100b - 12210) / 36525), numerator biased by 5000 * 36525
  localparam int NC_W = 30;
  localparam logic signed [31:0] NC_ADD = 32'sd182612790;
  localparam logic [30:0] C_MUL = 31'd1926591217;
  localparam int C_SHIFT = 46;
  localparam int C_PW = 61;
  localparam logic signed [15:0] C_BIAS = 16'sd5000;

  localparam logic signed [26:0] D_MUL = 27'sd1461;

  // e = floor(10000 x / 306001)
  localparam int NE_W = 23;
  localparam logic [NE_W-1:0] NE_MUL = 23'd10000;
  localparam logic [23:0] E_MUL = 24'd14372655;
  localparam int E_SHIFT = 42;
  localparam int E_PW = 47;

  localparam logic signed [15:0] YEAR_LATE = 16'sd4716;
  localparam logic signed [15:0] YEAR_EARLY = 16'sd4715;

  // time of day split
  localparam logic [27:0] MIN_MUL = 28'd146601551;
  localparam int MIN_SHIFT = 43;
  localparam int MIN_PW = 55;
  localparam logic [MS_W-1:0] MS_PER_MIN = 27'd60000;
  localparam logic [11:0] HR_MUL = 12'd2185;
  localparam int HR_SHIFT = 17;
  localparam int HR_PW = 23;

  localparam int DATE_STAGES = 11;
  localparam int TIME_STAGES = 5;
  localparam int TIME_PAD = DATE_STAGES - TIME_STAGES;
  localparam int LATENCY = DATE_STAGES + 1;

  typedef struct packed {
    logic signed [MJD_W-1:0] mjd_day;
    logic [MS_W-1:0]         ms_of_day;
  } item_t;

  typedef struct packed {
    logic signed [14:0] year;
    logic [3:0]         month;
    logic [4:0]         day_of_month;
  } date_t;

  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [15:0] milli_in_minute;
  } tod_t;

  typedef struct packed {
    logic signed [14:0] year;
    logic [3:0]         month;
    logic [4:0]         day_of_month;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [15:0]        milli_in_minute;
  } result_t;

  // floor(30.6001 * e)
  function automatic logic [8:0] month_days(input logic [3:0] e);
    logic [8:0] r;
    case (e)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      4'd15:   r = 9'd459;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

@@ src/mjdc_date.sv @@
// date pipeline: julian day number to year, month and day
module mjdc_date (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                valid_in,
  input  logic signed [mjdc_pkg::Z_W-1:0]     z_in,
  output logic                                valid_out,
  output mjdc_pkg::date_t                     date
);

  logic [mjdc_pkg::DATE_STAGES-1:0] vld;

  logic                              greg2, greg3;
  logic signed [mjdc_pkg::Z_W-1:0]   z2, z3;
  logic [mjdc_pkg::AN_W-1:0]         an2;
  logic [26:0]                       an_full;
  logic [mjdc_pkg::ALPHA_PW-1:0]     prod_a3;
  logic [7:0]                        alpha;
  logic [7:0]                        adj;
  logic signed [mjdc_pkg::Z_W-1:0]   b4, b5, b6, b7, b8;
  logic signed [31:0]                nc_full;
  logic [mjdc_pkg::NC_W-1:0]         nc5;
  logic [mjdc_pkg::C_PW-1:0]         prod_c6;
  logic signed [15:0]                c7, c8, c9, c10, c11;
  logic signed [26:0]                prod_d8;
  logic signed [24:0]                xd;
  logic [8:0]                        x9, x10, x11;
  logic [mjdc_pkg::NE_W-1:0]         ne10;
  logic [mjdc_pkg::E_PW-1:0]         prod_e11;
  logic [3:0]                        e;
  logic [8:0]                        day_full;
  logic [3:0]                        month_next;
  logic signed [15:0]                year_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[mjdc_pkg::DATE_STAGES-2:0], valid_in};
    end
  end

  // gregorian correction numerator
  assign an_full = {z_in[mjdc_pkg::Z_W-1], z_in, 2'b00} - mjdc_pkg::ALPHA_BIAS;

  always_ff @(posedge clk) begin
    z2    <= z_in;
    greg2 <= (z_in >= mjdc_pkg::GREG_START);
    an2   <= (z_in >= mjdc_pkg::GREG_START) ? an_full[mjdc_pkg::AN_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    z3      <= z2;
    greg3   <= greg2;
    prod_a3 <= mjdc_pkg::ALPHA_PW'(an2) * mjdc_pkg::ALPHA_PW'(mjdc_pkg::ALPHA_MUL);
  end

  assign alpha = prod_a3[mjdc_pkg::ALPHA_SHIFT+7:mjdc_pkg::ALPHA_SHIFT];
  assign adj   = greg3 ? (alpha - {2'b00, alpha[7:2]} + 8'd1) : 8'd0;

  always_ff @(posedge clk) begin
    b4 <= z3 + $signed({16'd0, adj}) + mjdc_pkg::B_OFFSET;
  end

  assign nc_full = 32'(b4) * 32'sd100 + mjdc_pkg::NC_ADD;

  always_ff @(posedge clk) begin
    b5  <= b4;
    nc5 <= nc_full[mjdc_pkg::NC_W-1:0];
  end

  always_ff @(posedge clk) begin
    b6      <= b5;
    prod_c6 <= mjdc_pkg::C_PW'(nc5) * mjdc_pkg::C_PW'(mjdc_pkg::C_MUL);
  end

  always_ff @(posedge clk) begin
    b7 <= b6;
    c7 <= $signed({1'b0, prod_c6[mjdc_pkg::C_SHIFT+14:mjdc_pkg::C_SHIFT]}) - mjdc_pkg::C_BIAS;
  end

  always_ff @(posedge clk) begin
    b8      <= b7;
    c8      <= c7;
    prod_d8 <= 27'(c7) * mjdc_pkg::D_MUL;
  end

  // day count into the year, counted from march
  assign xd = 25'(b8) - $signed(prod_d8[26:2]);

  always_ff @(posedge clk) begin
    c9 <= c8;
    x9 <= xd[8:0];
  end

  always_ff @(posedge clk) begin
    c10  <= c9;
    x10  <= x9;
    ne10 <= mjdc_pkg::NE_W'(x9) * mjdc_pkg::NE_MUL;
  end

  always_ff @(posedge clk) begin
    c11      <= c10;
    x11      <= x10;
    prod_e11 <= mjdc_pkg::E_PW'(ne10) * mjdc_pkg::E_PW'(mjdc_pkg::E_MUL);
  end

  assign e          = prod_e11[mjdc_pkg::E_SHIFT+3:mjdc_pkg::E_SHIFT];
  assign day_full   = x11 - mjdc_pkg::month_days(e);
  assign month_next = (e < 4'd14) ? (e - 4'd1) : (e - 4'd13);
  assign year_full  = (month_next > 4'd2) ? (c11 - mjdc_pkg::YEAR_LATE)
                                          : (c11 - mjdc_pkg::YEAR_EARLY);

  always_ff @(posedge clk) begin
    date.year         <= year_full[14:0];
    date.month        <= month_next;
    date.day_of_month <= day_full[4:0];
  end

  assign valid_out = vld[mjdc_pkg::DATE_STAGES-1];

endmodule

@@ src/mjdc_time.sv @@
// time of day pipeline: milliseconds to hour, minute and milliseconds in the minute
module mjdc_time (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         valid_in,
  input  logic [mjdc_pkg::MS_W-1:0]    ms_in,
  output logic                         valid_out,
  output mjdc_pkg::tod_t               tod
);

  logic [mjdc_pkg::TIME_STAGES-1:0] vld;
  logic [mjdc_pkg::TIME_PAD-1:0]    pad_v;
  mjdc_pkg::tod_t                   pad_q [mjdc_pkg::TIME_PAD];

  logic [mjdc_pkg::MIN_PW-1:0] prod_tm;
  logic [mjdc_pkg::MS_W-1:0]   ms_a, ms_b;
  logic [10:0]                 tm_b, tm_c, tm_d;
  logic [mjdc_pkg::MS_W-1:0]   milli_full;
  logic [15:0]                 milli_c, milli_d;
  logic [mjdc_pkg::HR_PW-1:0]  prod_hr;
  logic [4:0]                  hour_d;
  logic [10:0]                 minute_full;
  mjdc_pkg::tod_t              tod_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      pad_v <= '0;
    end else begin
      vld   <= {vld[mjdc_pkg::TIME_STAGES-2:0], valid_in};
      pad_v <= {pad_v[mjdc_pkg::TIME_PAD-2:0], vld[mjdc_pkg::TIME_STAGES-1]};
    end
  end

  always_ff @(posedge clk) begin
    ms_a    <= ms_in;
    prod_tm <= mjdc_pkg::MIN_PW'(ms_in) * mjdc_pkg::MIN_PW'(mjdc_pkg::MIN_MUL);
  end

  always_ff @(posedge clk) begin
    ms_b <= ms_a;
    tm_b <= prod_tm[mjdc_pkg::MIN_SHIFT+10:mjdc_pkg::MIN_SHIFT];
  end

  assign milli_full = ms_b - mjdc_pkg::MS_W'(tm_b) * mjdc_pkg::MS_PER_MIN;

  always_ff @(posedge clk) begin
    tm_c    <= tm_b;
    milli_c <= milli_full[15:0];
    prod_hr <= mjdc_pkg::HR_PW'(tm_b) * mjdc_pkg::HR_PW'(mjdc_pkg::HR_MUL);
  end

  always_ff @(posedge clk) begin
    tm_d    <= tm_c;
    milli_d <= milli_c;
    hour_d  <= prod_hr[mjdc_pkg::HR_SHIFT+4:mjdc_pkg::HR_SHIFT];
  end

  assign minute_full = tm_d - 11'(hour_d) * 11'd60;

  always_ff @(posedge clk) begin
    tod_e.hour            <= hour_d;
    tod_e.minute          <= minute_full[5:0];
    tod_e.milli_in_minute <= milli_d;
  end

  // delay line to line up with the date pipeline
  always_ff @(posedge clk) begin
    pad_q[0] <= tod_e;
    for (int i = 1; i < mjdc_pkg::TIME_PAD; i++) begin
      pad_q[i] <= pad_q[i-1];
    end
  end

  assign tod       = pad_q[mjdc_pkg::TIME_PAD-1];
  assign valid_out = pad_v[mjdc_pkg::TIME_PAD-1];

endmodule

@@ src/modified_julian_day_to_calendar_date.sv @@
// top level: modified julian day and time of day to calendar date and time
//
//   channel | handshake      | payload
//   --------+----------------+------------------------------------------
//   in      | start / busy   | item   (mjd_day, ms_of_day)
//   out     | done (strobe)  | result (year, month, day_of_month,
//           |                |         hour, minute, milli_in_minute)
//
// one transfer per cycle while busy is low; results leave in the order of their transfers
// the depth is set by the date path: three constant-reciprocal divisions,
// each a multiply stage followed by a shift-and-adjust stage
// busy is high only while rst is high; reset clears the valid bits only
// results cannot be held off, so the pipeline never stalls
module modified_julian_day_to_calendar_date (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mjdc_pkg::item_t     item,
  output logic                done,
  output mjdc_pkg::result_t   result
);

  logic                             take;
  logic                             wrap;
  logic                             v1;
  logic signed [mjdc_pkg::Z_W-1:0]  z1;
  logic [mjdc_pkg::MS_W-1:0]        ms1;
  logic                             date_valid;
  logic                             time_valid;
  mjdc_pkg::date_t                  date;
  mjdc_pkg::tod_t                   tod;

  assign busy = rst;
  assign take = start && !busy;

  // time of day past midnight carries into the next day
  assign wrap = (item.ms_of_day >= mjdc_pkg::MS_PER_DAY);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= take;
    end
  end

  always_ff @(posedge clk) begin
    ms1 <= wrap ? (item.ms_of_day - mjdc_pkg::MS_PER_DAY) : item.ms_of_day;
    z1  <= mjdc_pkg::Z_W'(item.mjd_day) + $signed({23'd0, wrap}) + mjdc_pkg::JD_OFFSET;
  end

  mjdc_date u_date (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (v1),
    .z_in      (z1),
    .valid_out (date_valid),
    .date      (date)
  );

  mjdc_time u_time (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (v1),
    .ms_in     (ms1),
    .valid_out (time_valid),
    .tod       (tod)
  );

  assign done                   = date_valid;
  assign result.year            = date.year;
  assign result.month           = date.month;
  assign result.day_of_month    = date.day_of_month;
  assign result.hour            = tod.hour;
  assign result.minute          = tod.minute;
  assign result.milli_in_minute = tod.milli_in_minute;

  a_paths_aligned: assert property (@(posedge clk) disable iff (rst)
    date_valid == time_valid)
    else $error("date and time paths out of step");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(take, mjdc_pkg::LATENCY))
    else $error("result without a matching transfer");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.month >= 4'd1 && result.month <= 4'd12 &&
              result.day_of_month >= 5'd1))
    else $error("month or day out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.hour <= 5'd23 && result.minute <= 6'd59 &&
              result.milli_in_minute <= 16'd59999))
    else $error("time of day out of range");

endmodule
